[design/nvst_pkg.sv]
package nvst_pkg;

  // Default table size
  localparam int SLOT_COUNT_DEF = 8;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int WORD_W   = 32;
  localparam int NAME_W   = 16;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic start;  // latch the accepted item, rewind the scan
    logic scan;   // one scan step
    logic push;   // load the result into the output register
  } nvst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
  } nvst_sts_t;

endpackage

[design/nvst_if.sv]
// Request channel
interface nvst_req_if;
  import nvst_pkg::*;
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [WORD_W-1:0]   data_word;
  logic [NAME_W-1:0]   insert_name;
  logic                remove_on_hit;

  modport source (output valid, opcode, data_word, insert_name, remove_on_hit,
                  input ready);
  modport sink (input valid, opcode, data_word, insert_name, remove_on_hit,
                output ready);
endinterface

// Response channel
interface nvst_rsp_if;
  import nvst_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] found_value;

  modport source (output valid, found_value, input ready);
  modport sink (input valid, found_value, output ready);
endinterface

[design/nvst_ram.sv]
module nvst_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/nvst_datapath.sv]
module nvst_datapath
  import nvst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  nvst_cmd_t           cmd,
  output nvst_sts_t           sts,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [WORD_W-1:0]   data_word,
  input  logic [NAME_W-1:0]   insert_name,
  input  logic                remove_on_hit,
  output logic [WORD_W-1:0]   found_value
);

  localparam int IDX_W   = $clog2(SLOT_COUNT);
  localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
  localparam int ENTRY_W = NAME_W + WORD_W;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(SLOT_COUNT - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SLOT_COUNT);

  // Latched item
  logic [OPCODE_W-1:0] op_q;
  logic [WORD_W-1:0]   word_q;
  logic [NAME_W-1:0]   name_q;
  logic                remove_q;

  // Scan state
  logic [CNT_W-1:0]      rd_cnt;
  logic [IDX_W-1:0]      chk_idx;
  logic                  chk_pend;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic [WORD_W-1:0]     res;

  // RAM signals
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;

  logic              is_ins;
  logic              is_lkp;
  logic [NAME_W-1:0] name_eff;
  logic [WORD_W-1:0] value_eff;
  logic              name_hit;
  logic              match;
  logic              last;
  logic              rd_more;

  // Entry whose valid bit is clear (never written since the last clear or reset, or removed) reads as empty and zero
  always_comb begin
    is_ins    = (op_q == OP_INSERT);
    is_lkp    = (op_q == OP_LOOKUP);
    name_eff  = slot_valid[chk_idx] ? ram_rdata[ENTRY_W-1:WORD_W] : '0;
    value_eff = slot_valid[chk_idx] ? ram_rdata[WORD_W-1:0] : '0;
    name_hit  = is_ins ? (name_eff == '0)
                       : ({{(WORD_W-NAME_W){1'b0}}, name_eff} == word_q);
    match     = chk_pend && (is_ins || is_lkp) && name_hit;
    last      = chk_pend && (chk_idx == LAST_IDX);
    rd_more   = (rd_cnt < CNT_LIMIT);
    sts.scan_done = !(is_ins || is_lkp) || match || last;
    ram_we    = cmd.scan && match && is_ins;
  end

  nvst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chk_idx),
    .wdata ({name_q, word_q}),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Scan control and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      chk_pend   <= 1'b0;
      rd_cnt     <= '0;
    end else if (cmd.start) begin
      chk_pend <= 1'b0;
      rd_cnt   <= '0;
    end else if (cmd.scan) begin
      // Read one slot ahead of the compare
      if (rd_more) begin
        rd_cnt   <= rd_cnt + CNT_W'(1);
        chk_pend <= 1'b1;
      end else begin
        chk_pend <= 1'b0;
      end
      if (op_q == OP_CLEAR) begin
        slot_valid <= '0;
      end else if (match) begin
        if (is_ins) begin
          slot_valid[chk_idx] <= 1'b1;
        end else if (remove_q) begin
          slot_valid[chk_idx] <= 1'b0;
        end
      end
    end
  end

  // Item, compare index and result
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_q     <= opcode;
      word_q   <= data_word;
      name_q   <= insert_name;
      remove_q <= remove_on_hit;
      res      <= '0;
    end else if (cmd.scan) begin
      chk_idx <= rd_cnt[IDX_W-1:0];
      if (match && is_lkp) begin
        res <= value_eff;
      end
    end
    if (cmd.push) begin
      found_value <= res;
    end
  end

endmodule

[design/nvst_ctrl.sv]
module nvst_ctrl
  import nvst_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output nvst_cmd_t cmd,
  input  nvst_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  // Commands and next state
  always_comb begin
    out_free   = !rsp_valid || rsp_ready;
    req_ready  = (state == ST_IDLE);
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[design/named_value_slot_table.sv]
// Table of SLOT_COUNT slots, each a 32-bit value with a 16-bit name (name zero
// marks a slot empty), held in a small RAM with a valid bit per slot so that
// reset and the clear opcode empty the table at once. Each item is accepted in
// the idle state, then the RAM is scanned at one slot a cycle with the compare
// in the cycle after the registered read, then the result is loaded into the
// output register. Clear and unused opcodes end the scan at once; insert and
// lookup stop at the first hit (an empty slot for insert, the named slot for
// lookup) or after the last slot. A new item is taken while the previous
// result still waits in the output register.
module named_value_slot_table
  import nvst_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  nvst_req_if.sink   req,
  nvst_rsp_if.source rsp
);

  nvst_cmd_t cmd;
  nvst_sts_t sts;

  nvst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nvst_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .opcode        (req.opcode),
    .data_word     (req.data_word),
    .insert_name   (req.insert_name),
    .remove_on_hit (req.remove_on_hit),
    .found_value   (rsp.found_value)
  );

endmodule
